[rtl/core/swfr_pkg.sv]
// Package with the shared types and constants of the sync word frame receiver.
`timescale 1ns / 1ps

package swfr_pkg;

   localparam logic [31:0] SYNC_WORD   = 32'h83ad83ad;
   localparam logic [31:0] FOOTER_WORD = 32'hf007f007;
   localparam logic [15:0] FOOTER_BYTES = 16'd4;

   // Control and status register indexes and their reset values.
   localparam logic [1:0] CSR_MAX_PAYLOAD_LEN   = 2'd0;
   localparam logic [1:0] CSR_STATE_TYPE_CODE   = 2'd1;
   localparam logic [1:0] CSR_STATE_PAYLOAD_LEN = 2'd2;

   localparam logic [15:0] MAX_PAYLOAD_LEN_RESET   = 16'd1024;
   localparam logic [7:0]  STATE_TYPE_CODE_RESET   = 8'd0;
   localparam logic [15:0] STATE_PAYLOAD_LEN_RESET = 16'd64;

   typedef enum logic [5:0] {
      PH_HUNT    = 6'b000001,
      PH_TYPE    = 6'b000010,
      PH_LEN_HI  = 6'b000100,
      PH_LEN_LO  = 6'b001000,
      PH_PAYLOAD = 6'b010000,
      PH_FOOTER  = 6'b100000
   } phase_type;

   typedef enum logic {
      KIND_PAYLOAD   = 1'b0,
      KIND_FRAME_END = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      ST_GOOD        = 2'd0,
      ST_LEN_TOO_BIG = 2'd1,
      ST_BAD_FOOTER  = 2'd2,
      ST_STATE_SIZE  = 2'd3
   } status_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data_byte;
      logic [15:0] byte_index;
      logic [7:0]  frame_type;
      logic [15:0] frame_len;
      status_type  status;
   } result_type;

endpackage

[rtl/core/sync_word_frame_receiver_top.sv]
// Top level of the sync word frame receiver: byte deframer with output skid stage.
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  req_rx_byte
// rsp_      out        rsp_valid/rsp_stall  rsp_kind, rsp_data_byte, rsp_byte_index,
//                                           rsp_frame_type, rsp_frame_len, rsp_status
// csr_      in         csr_write_enable     csr_index, csr_write_data
//
// Every accepted byte is handled in the cycle it is accepted, so the block takes one
// transaction per clock while req_stall is low; each result is registered before rsp_.
// The limit is the single deframing state machine, which updates once per byte.
// Reset is synchronous and active high; it returns the block to sync hunting and
// restores the register defaults. A stalled result waits in the output register while a
// second one fills the skid register; req_stall rises only when the skid is occupied.

module sync_word_frame_receiver_top (
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_rx_byte,

   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_kind,
   output logic [7:0]          rsp_data_byte,
   output logic [15:0]         rsp_byte_index,
   output logic [7:0]          rsp_frame_type,
   output logic [15:0]         rsp_frame_len,
   output logic [1:0]          rsp_status,

   input  logic                csr_write_enable,
   input  logic [1:0]          csr_index,
   input  logic [15:0]         csr_write_data
);

   // Configuration registers.
   logic [15:0] max_payload_len_ff;
   logic [7:0]  state_type_code_ff;
   logic [15:0] state_payload_len_ff;

   // Deframer state.
   swfr_pkg::phase_type phase_ff, phase_in;
   logic [31:0] sync_shift_ff, sync_shift_in;
   logic [7:0]  cur_type_ff, cur_type_in;
   logic [15:0] cur_len_ff, cur_len_in;
   logic [15:0] byte_count_ff, byte_count_in;
   logic [31:0] footer_shift_ff, footer_shift_in;

   // Output register and skid register.
   logic                 out_valid_ff;
   swfr_pkg::result_type out_data_ff;
   logic                 skid_valid_ff;
   swfr_pkg::result_type skid_data_ff;

   logic                 req_accept;
   logic                 out_take;
   logic                 res_valid;
   swfr_pkg::result_type res_data;

   logic [15:0] count_inc;
   logic [15:0] len_full;
   logic [31:0] sync_next;
   logic [31:0] footer_next;

   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !req_stall;
   assign out_take   = out_valid_ff && !rsp_stall;

   assign count_inc   = byte_count_ff + 16'd1;
   assign len_full    = {cur_len_ff[15:8], req_rx_byte};
   assign sync_next   = {sync_shift_ff[23:0], req_rx_byte};
   assign footer_next = {footer_shift_ff[23:0], req_rx_byte};

   // Configuration writes are registered.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_len_ff   <= swfr_pkg::MAX_PAYLOAD_LEN_RESET;
         state_type_code_ff   <= swfr_pkg::STATE_TYPE_CODE_RESET;
         state_payload_len_ff <= swfr_pkg::STATE_PAYLOAD_LEN_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            swfr_pkg::CSR_MAX_PAYLOAD_LEN:   max_payload_len_ff   <= csr_write_data;
            swfr_pkg::CSR_STATE_TYPE_CODE:   state_type_code_ff   <= csr_write_data[7:0];
            swfr_pkg::CSR_STATE_PAYLOAD_LEN: state_payload_len_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Deframing step for the byte at the input. The result carries the frame fields as
   // they stand after this byte has been taken in.
   always_comb begin
      phase_in        = phase_ff;
      sync_shift_in   = sync_shift_ff;
      cur_type_in     = cur_type_ff;
      cur_len_in      = cur_len_ff;
      byte_count_in   = byte_count_ff;
      footer_shift_in = footer_shift_ff;
      res_valid       = 1'b0;
      res_data.kind       = swfr_pkg::KIND_FRAME_END;
      res_data.data_byte  = 8'd0;
      res_data.byte_index = 16'd0;
      res_data.frame_type = cur_type_ff;
      res_data.frame_len  = cur_len_ff;
      res_data.status     = swfr_pkg::ST_GOOD;

      unique case (phase_ff)
         swfr_pkg::PH_TYPE: begin
            cur_type_in = req_rx_byte;
            phase_in    = swfr_pkg::PH_LEN_HI;
         end
         swfr_pkg::PH_LEN_HI: begin
            cur_len_in = {req_rx_byte, 8'd0};
            phase_in   = swfr_pkg::PH_LEN_LO;
         end
         swfr_pkg::PH_LEN_LO: begin
            cur_len_in      = len_full;
            byte_count_in   = 16'd0;
            footer_shift_in = 32'd0;
            res_data.frame_len = len_full;
            if (len_full > max_payload_len_ff) begin
               // Oversized frames are rejected as soon as the length is known.
               phase_in        = swfr_pkg::PH_HUNT;
               res_valid       = 1'b1;
               res_data.status = swfr_pkg::ST_LEN_TOO_BIG;
            end else if (len_full == 16'd0) begin
               phase_in = swfr_pkg::PH_FOOTER;
            end else begin
               phase_in = swfr_pkg::PH_PAYLOAD;
            end
         end
         swfr_pkg::PH_PAYLOAD: begin
            res_valid           = 1'b1;
            res_data.kind       = swfr_pkg::KIND_PAYLOAD;
            res_data.data_byte  = req_rx_byte;
            res_data.byte_index = byte_count_ff;
            if (count_inc >= cur_len_ff) begin
               byte_count_in   = 16'd0;
               footer_shift_in = 32'd0;
               phase_in        = swfr_pkg::PH_FOOTER;
            end else begin
               byte_count_in = count_inc;
            end
         end
         swfr_pkg::PH_FOOTER: begin
            footer_shift_in = footer_next;
            byte_count_in   = count_inc;
            if (count_inc >= swfr_pkg::FOOTER_BYTES) begin
               phase_in      = swfr_pkg::PH_HUNT;
               byte_count_in = 16'd0;
               res_valid     = 1'b1;
               if (footer_next != swfr_pkg::FOOTER_WORD) begin
                  res_data.status = swfr_pkg::ST_BAD_FOOTER;
               end else if (cur_type_ff == state_type_code_ff &&
                            cur_len_ff != state_payload_len_ff) begin
                  res_data.status = swfr_pkg::ST_STATE_SIZE;
               end
            end
         end
         default: begin
            // Hunting; a matched sync word clears the shift register so the next
            // hunt starts from nothing.
            phase_in      = swfr_pkg::PH_HUNT;
            sync_shift_in = sync_next;
            if (sync_next == swfr_pkg::SYNC_WORD) begin
               sync_shift_in = 32'd0;
               phase_in      = swfr_pkg::PH_TYPE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= swfr_pkg::PH_HUNT;
         sync_shift_ff   <= 32'd0;
         cur_type_ff     <= 8'd0;
         cur_len_ff      <= 16'd0;
         byte_count_ff   <= 16'd0;
         footer_shift_ff <= 32'd0;
      end else if (req_accept) begin
         phase_ff        <= phase_in;
         sync_shift_ff   <= sync_shift_in;
         cur_type_ff     <= cur_type_in;
         cur_len_ff      <= cur_len_in;
         byte_count_ff   <= byte_count_in;
         footer_shift_ff <= footer_shift_in;
      end
   end

   // Output register with skid. New results go straight to the output register when it
   // is free or being drained; otherwise they park in the skid register, which stalls
   // the input until the output register takes it over.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_take) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (!out_valid_ff || out_take) begin
         out_valid_ff <= req_accept && res_valid;
      end else if (req_accept && res_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (out_take) begin
            out_data_ff <= skid_data_ff;
         end
      end else if (!out_valid_ff || out_take) begin
         out_data_ff <= res_data;
      end else begin
         skid_data_ff <= res_data;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_kind       = out_data_ff.kind;
   assign rsp_data_byte  = out_data_ff.data_byte;
   assign rsp_byte_index = out_data_ff.byte_index;
   assign rsp_frame_type = out_data_ff.frame_type;
   assign rsp_frame_len  = out_data_ff.frame_len;
   assign rsp_status     = out_data_ff.status;

endmodule
